// ----- src/utc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_pkg - shared types and constants of the UTF-8 to CP1251 transcoder
// Lead codes, register indexes, byte constants and the record that carries
// the results of one input byte from the front end to the back end.
// ----------------------------------------------------------------------------
package utc_pkg;

	// byte and register widths
	localparam int BYTE_W  = 8;
	localparam int CFG_IDX_W = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR_LIMIT = 1'd1;

	// register reset values
	localparam logic [BYTE_W-1:0] OUT_LIMIT_RST  = 8'd64;
	localparam logic [BYTE_W-1:0] PAIR_LIMIT_RST = 8'd64;

	// held lead codes
	localparam logic [1:0] LEAD_NONE = 2'd0;
	localparam logic [1:0] LEAD_D0   = 2'd1;
	localparam logic [1:0] LEAD_D1   = 2'd2;

	// byte constants
	localparam logic [BYTE_W-1:0] BYTE_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] BYTE_D0    = 8'hD0;
	localparam logic [BYTE_W-1:0] BYTE_D1    = 8'hD1;
	localparam logic [BYTE_W-1:0] BYTE_IO_D0 = 8'h81;
	localparam logic [BYTE_W-1:0] BYTE_IO_D1 = 8'h91;
	localparam logic [BYTE_W-1:0] CP_IO_UC   = 8'd168;
	localparam logic [BYTE_W-1:0] CP_IO_LC   = 8'd184;
	localparam logic [BYTE_W-1:0] D0_LO      = 8'h90;
	localparam logic [BYTE_W-1:0] D0_HI      = 8'hBF;
	localparam logic [BYTE_W-1:0] D0_OFS     = 8'd48;
	localparam logic [BYTE_W-1:0] D1_LO      = 8'h80;
	localparam logic [BYTE_W-1:0] D1_HI      = 8'h8F;
	localparam logic [BYTE_W-1:0] D1_OFS     = 8'd112;
	localparam logic [BYTE_W-1:0] IDX_MAX    = 8'd255;

	// queue between front and back end
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// one result
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              has;
		logic              eos;
	} res_t;

	// all results of one input byte (one or two)
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} rec_t;

	// configuration seen by the front end
	typedef struct packed {
		logic [BYTE_W-1:0] out_limit;
		logic [BYTE_W-1:0] pair_limit;
	} cfg_t;

endpackage

// ----- src/utf8_cyrillic_to_cp1251_transcoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_cyrillic_to_cp1251_transcoder - UTF-8 Cyrillic to CP1251 transcoder
// Turns a zero-terminated UTF-8 byte stream into CP1251 bytes.
// ----------------------------------------------------------------------------
// Usage:
//  Input is a queue write: drive in_byte and push; the byte is taken on a
//  clock edge with push high and full low. One byte can be taken every cycle.
//  Results are a queue read: while empty is low the oldest result sits on
//  out_byte/has_byte/end_of_string/last_of_run and leaves on a cycle with pop
//  high. A byte gives no, one or two results; a zero byte ends the string
//  with a bare end marker (has_byte low, end_of_string high).
//  A record goes into the queue and then into the output register.
//  Throughput: one byte per cycle while each gives at most one result and pop
//  is high; a byte with two results occupies the single output register for
//  two pops, which the four-record queue absorbs. The output register hands
//  out one result per cycle while pop is high, which sets the sustained rate.
//  A stalled receiver fills the queue, after which full rises and input
//  stops; nothing is lost.
//  Registers (wr_en/wr_index/wr_data): 0 out_limit, 1 pair_limit, both 64
//  after reset. Reset clears the queue, the held lead and the counters.
// ----------------------------------------------------------------------------
module utf8_cyrillic_to_cp1251_transcoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [utc_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [utc_pkg::BYTE_W-1:0]    wr_data,
	input  logic                          push,
	output logic                          full,
	input  logic [utc_pkg::BYTE_W-1:0]    in_byte,
	output logic                          empty,
	input  logic                          pop,
	output logic [utc_pkg::BYTE_W-1:0]    out_byte,
	output logic                          has_byte,
	output logic                          end_of_string,
	output logic                          last_of_run
);
	import utc_pkg::*;

	cfg_t cfg_q;
	logic accept;
	logic rec_push;
	rec_t rec;
	rec_t q_rec;
	logic q_rd;
	logic q_avail;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.out_limit  <= OUT_LIMIT_RST;
			cfg_q.pair_limit <= PAIR_LIMIT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_OUT_LIMIT:  cfg_q.out_limit  <= wr_data;
				REG_PAIR_LIMIT: cfg_q.pair_limit <= wr_data;
				default: ;
			endcase
		end
	end

	assign accept = push && !full;

	utc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.accept   (accept),
		.in_byte  (in_byte),
		.rec_push (rec_push),
		.rec      (rec)
	);

	utc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (rec_push),
		.wr_rec    (rec),
		.rd        (q_rd),
		.rd_rec    (q_rec),
		.full      (full),
		.not_empty (q_avail)
	);

	utc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_avail       (q_avail),
		.q_rec         (q_rec),
		.q_rd          (q_rd),
		.pop           (pop),
		.empty         (empty),
		.out_byte      (out_byte),
		.has_byte      (has_byte),
		.end_of_string (end_of_string),
		.last_of_run   (last_of_run)
	);

endmodule

// ----- src/utc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_front - input side of the transcoder
// Takes one byte a cycle when accepted, tracks the held lead, byte index and
// output count, and builds the record of results that the byte causes.
// ----------------------------------------------------------------------------
module utc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  utc_pkg::cfg_t              cfg,
	input  logic                       accept,
	input  logic [utc_pkg::BYTE_W-1:0] in_byte,
	output logic                       rec_push,
	output utc_pkg::rec_t              rec
);
	import utc_pkg::*;

	logic [1:0]        held_q;
	logic [BYTE_W-1:0] index_q;
	logic [BYTE_W-1:0] count_q;

	logic [1:0]        lead;
	logic [BYTE_W-1:0] lead_b;
	logic              is_nul;
	logic              pair_hit;
	logic [BYTE_W-1:0] pair_b;
	logic              room0;
	logic              room1;
	logic              e0;
	logic              e1;
	logic [BYTE_W-1:0] cnt1;
	logic              may_pair;
	logic              hold;
	logic [1:0]        in_code;
	logic [1:0]        held_d;
	logic [BYTE_W-1:0] index_d;
	logic [BYTE_W-1:0] count_d;
	res_t              eos_res;
	res_t              res_a;
	res_t              res_b;

	// lead decode of the stored state and the incoming byte
	always_comb begin
		lead    = (held_q == LEAD_D0 || held_q == LEAD_D1) ? held_q : LEAD_NONE;
		lead_b  = (lead == LEAD_D0) ? BYTE_D0 : BYTE_D1;
		is_nul  = (in_byte == BYTE_NUL);
		in_code = (in_byte == BYTE_D0) ? LEAD_D0 :
		          (in_byte == BYTE_D1) ? LEAD_D1 : LEAD_NONE;
		may_pair = ({1'b0, index_q} + 9'd1) < {1'b0, cfg.pair_limit};
	end

	// recognised pairs
	always_comb begin
		pair_hit = 1'b0;
		pair_b   = in_byte;
		priority if (lead == LEAD_D0 && in_byte == BYTE_IO_D0) begin
			pair_hit = 1'b1;
			pair_b   = CP_IO_UC;
		end else if (lead == LEAD_D1 && in_byte == BYTE_IO_D1) begin
			pair_hit = 1'b1;
			pair_b   = CP_IO_LC;
		end else if (lead == LEAD_D0 && in_byte >= D0_LO && in_byte <= D0_HI) begin
			pair_hit = 1'b1;
			pair_b   = in_byte + D0_OFS;
		end else if (lead == LEAD_D1 && in_byte >= D1_LO && in_byte <= D1_HI) begin
			pair_hit = 1'b1;
			pair_b   = in_byte + D1_OFS;
		end else begin
			pair_hit = 1'b0;
			pair_b   = in_byte;
		end
	end

	// result build and next state
	always_comb begin
		eos_res = '{data: BYTE_NUL, has: 1'b0, eos: 1'b1};
		room0   = count_q < cfg.out_limit;
		e0      = 1'b0;
		e1      = 1'b0;
		hold    = 1'b0;
		res_a   = '{data: lead_b, has: 1'b1, eos: 1'b0};
		res_b   = '{data: in_byte, has: 1'b1, eos: 1'b0};
		held_d  = LEAD_NONE;
		index_d = (index_q < IDX_MAX) ? index_q + 8'd1 : index_q;

		if (is_nul) begin
			// flush a held lead, then the end marker
			e0      = (lead != LEAD_NONE) && room0;
			e1      = 1'b1;
			res_b   = eos_res;
			index_d = '0;
		end else if (pair_hit) begin
			e1         = room0;
			res_b.data = pair_b;
		end else begin
			e0   = (lead != LEAD_NONE) && room0;
			hold = (in_code != LEAD_NONE) && may_pair;
			if (hold) begin
				held_d = in_code;
			end
		end

		// room for the follower counts the lead emitted just before it
		cnt1  = count_q + {7'd0, e0};
		room1 = cnt1 < cfg.out_limit;
		if (!is_nul && !pair_hit) begin
			e1 = !hold && room1;
		end
		count_d = is_nul ? '0 : cnt1 + {7'd0, (e1 && res_b.has)};

		rec_push = accept && (e0 || e1);
		rec.two  = e0 && e1;
		rec.r0   = e0 ? res_a : res_b;
		rec.r1   = res_b;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= LEAD_NONE;
			index_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			held_q  <= held_d;
			index_q <= index_d;
			count_q <= count_d;
		end
	end

	// held lead only ever takes a defined code
	a_held_code: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != 2'd3)
		else $error("held lead took an undefined code");

	// a zero byte always leaves a record
	a_nul_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_nul) |-> rec_push)
		else $error("end marker not queued");

endmodule

// ----- src/utc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_queue - short record queue between front and back end
// Flip-flop circular buffer, one write and one read a cycle.
// ----------------------------------------------------------------------------
module utc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  utc_pkg::rec_t wr_rec,
	input  logic          rd,
	output utc_pkg::rec_t rd_rec,
	output logic          full,
	output logic          not_empty
);
	import utc_pkg::*;

	rec_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_rec    = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(wr) - QCNT_W'(rd);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> not_empty)
		else $error("queue read while empty");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !full)
		else $error("queue written while full");

endmodule

// ----- src/utc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_back - result side of the transcoder
// Holds one record in the output register and hands out its one or two
// results, marking the final one of each input byte.
// ----------------------------------------------------------------------------
module utc_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_avail,
	input  utc_pkg::rec_t              q_rec,
	output logic                       q_rd,
	input  logic                       pop,
	output logic                       empty,
	output logic [utc_pkg::BYTE_W-1:0] out_byte,
	output logic                       has_byte,
	output logic                       end_of_string,
	output logic                       last_of_run
);
	import utc_pkg::*;

	logic valid_q;
	logic phase_q;
	rec_t rec_q;
	res_t cur;
	logic take;
	logic done;

	// current result
	assign cur           = phase_q ? rec_q.r1 : rec_q.r0;
	assign empty         = !valid_q;
	assign out_byte      = cur.data;
	assign has_byte      = cur.has;
	assign end_of_string = cur.eos;
	assign last_of_run   = !rec_q.two || phase_q;

	// request taken and record finished
	assign take = valid_q && pop;
	assign done = take && last_of_run;
	assign q_rd = q_avail && (!valid_q || done);

	// output register
	always_ff @(posedge clk) begin
		if (q_rd) begin
			rec_q <= q_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (q_rd) begin
				valid_q <= 1'b1;
				phase_q <= 1'b0;
			end else if (done) begin
				valid_q <= 1'b0;
				phase_q <= 1'b0;
			end else if (take) begin
				phase_q <= 1'b1;
			end
		end
	end

	a_phase_two: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (valid_q && rec_q.two))
		else $error("second result shown for a single record");

endmodule
